// ===== src/cdfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdfs_pkg: shared types and constants for the clock display frame sequencer
// Word formats, register indexes, command codes, link byte constants and
// the decimal digit / seven-segment helpers.
// ----------------------------------------------------------------------------
package cdfs_pkg;

    // Command codes
    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_SHOW = 1'b1;

    // Configuration register indexes
    localparam int  CFG_IDX_W  = 1;
    localparam int  CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ON = 1'd1;

    localparam logic [2:0] BRIGHTNESS_RESET = 3'd7;
    localparam logic       DISPLAY_ON_RESET = 1'b1;

    // Link bytes
    localparam logic [7:0] BYTE_DATA_CMD  = 8'h40;
    localparam logic [7:0] BYTE_ADDR_CMD  = 8'hC0;
    localparam logic       CTRL_CMD_FLAG  = 1'b1;
    localparam logic [7:0] BYTE_BLANK     = 8'h00;

    // Sequence steps
    localparam int  STEP_W         = 3;
    localparam logic [STEP_W-1:0] STEP_DATA_CMD  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SECOND    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_HOUR_TENS = 3'd2;
    localparam logic [STEP_W-1:0] STEP_HOUR_UNIT = 3'd3;
    localparam logic [STEP_W-1:0] STEP_MIN_TENS  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_MIN_UNIT  = 3'd5;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic       command;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic       blank_hours;
        logic       blank_minutes;
    } t_in_word;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } t_out_word;

    // Classified item handed from front to back
    typedef struct packed {
        logic       is_show;
        logic [7:0] ctrl_byte;
        logic [7:0] seg_hour_tens;
        logic [7:0] seg_hour_unit;
        logic [7:0] seg_min_tens;
        logic [7:0] seg_min_unit;
    } t_frame;

    // Segment pattern of one decimal digit
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // v / 10 via reciprocal multiply, exact for every 7-bit v
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] prod;
        prod = {8'd0, v} * 15'd205;
        return prod[14:11];
    endfunction

    // Tens digit; drop the hundreds for values of 100 and above
    function automatic logic [3:0] tens_digit(input logic [6:0] v);
        logic [3:0] q;
        q = div10(v);
        if (q >= 4'd10) begin
            q = q - 4'd10;
        end
        return q;
    endfunction

    function automatic logic [3:0] unit_digit(input logic [6:0] v);
        logic [3:0] q;
        logic [6:0] r;
        q = div10(v);
        r = v - ({3'd0, q} * 7'd10);
        return r[3:0];
    endfunction

endpackage

// ===== src/cdfs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdfs_front: item classifier
// Turns an input word into a frame: command kind, control byte and the four
// segment bytes with blanking applied.
// ----------------------------------------------------------------------------
module cdfs_front (
    input  wire cdfs_pkg::t_in_word i_word,
    input  wire logic [2:0]         i_brightness,
    input  wire logic               i_display_on,
    output cdfs_pkg::t_frame        o_frame
);

    always_comb begin
        o_frame.is_show   = (i_word.command == cdfs_pkg::CMD_SHOW);
        o_frame.ctrl_byte = {cdfs_pkg::CTRL_CMD_FLAG, 3'd0, i_display_on, i_brightness};
        if (i_word.blank_hours) begin
            o_frame.seg_hour_tens = cdfs_pkg::BYTE_BLANK;
            o_frame.seg_hour_unit = cdfs_pkg::BYTE_BLANK;
        end else begin
            o_frame.seg_hour_tens = cdfs_pkg::seg_of(cdfs_pkg::tens_digit(i_word.hours));
            o_frame.seg_hour_unit = cdfs_pkg::seg_of(cdfs_pkg::unit_digit(i_word.hours));
        end
        if (i_word.blank_minutes) begin
            o_frame.seg_min_tens = cdfs_pkg::BYTE_BLANK;
            o_frame.seg_min_unit = cdfs_pkg::BYTE_BLANK;
        end else begin
            o_frame.seg_min_tens = cdfs_pkg::seg_of(cdfs_pkg::tens_digit(i_word.minutes));
            o_frame.seg_min_unit = cdfs_pkg::seg_of(cdfs_pkg::unit_digit(i_word.minutes));
        end
    end

endmodule
`default_nettype wire

// ===== src/cdfs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdfs_queue: frame queue
// Small register FIFO between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module cdfs_queue #(
    parameter int DEPTH = cdfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire cdfs_pkg::t_frame i_frame,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output cdfs_pkg::t_frame      o_frame
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cdfs_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule
`default_nettype wire

// ===== src/cdfs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdfs_back: byte sequencer
// Steps through the bytes of the head frame, one per cycle while the output is
// not stalled, into an output register; pops the frame after its last byte.
// ----------------------------------------------------------------------------
module cdfs_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_frame_valid,
    input  wire cdfs_pkg::t_frame   i_frame,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output cdfs_pkg::t_out_word     o_out_word
);

    logic [cdfs_pkg::STEP_W-1:0] r_step, n_step;
    logic                        r_out_valid, n_out_valid;
    cdfs_pkg::t_out_word         r_out_word;
    cdfs_pkg::t_out_word         w_word;
    logic                        w_load;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Byte for the current step
    always_comb begin
        case (r_step)
            cdfs_pkg::STEP_DATA_CMD:
                w_word = '{cdfs_pkg::BYTE_DATA_CMD, 1'b1, 1'b1, 1'b0};
            cdfs_pkg::STEP_SECOND:
                if (i_frame.is_show) begin
                    w_word = '{cdfs_pkg::BYTE_ADDR_CMD, 1'b1, 1'b0, 1'b0};
                end else begin
                    w_word = '{i_frame.ctrl_byte, 1'b1, 1'b1, 1'b1};
                end
            cdfs_pkg::STEP_HOUR_TENS:
                w_word = '{i_frame.seg_hour_tens, 1'b0, 1'b0, 1'b0};
            cdfs_pkg::STEP_HOUR_UNIT:
                w_word = '{i_frame.seg_hour_unit, 1'b0, 1'b0, 1'b0};
            cdfs_pkg::STEP_MIN_TENS:
                w_word = '{i_frame.seg_min_tens, 1'b0, 1'b0, 1'b0};
            cdfs_pkg::STEP_MIN_UNIT:
                w_word = '{i_frame.seg_min_unit, 1'b0, 1'b1, 1'b1};
            default:
                w_word = '{8'h00, 1'b0, 1'b0, 1'b1};
        endcase
    end

    assign w_load = i_frame_valid && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_load && w_word.last;

    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_step      = w_word.last ? cdfs_pkg::STEP_DATA_CMD : r_step + 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= cdfs_pkg::STEP_DATA_CMD;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word <= w_word;
        end
    end

endmodule
`default_nettype wire

// ===== src/clock_display_frame_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_display_frame_sequencer: byte sequencer for a 4-digit 7-segment link
// Expands init and show-time commands into framed link bytes.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | word
//  ---------+----------------------------+-------------------------------------
//  in       | i_in_valid / o_in_stall    | t_in_word: command, time, blanking
//  out      | o_out_valid / i_out_stall  | t_out_word: byte, start, stop, last
//  config   | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// An init command yields 2 words and a show command 6; the rate is set by the
// single output register, one byte per clock while the output is not stalled.
// The frame queue holds QUEUE_DEPTH classified commands; o_in_stall rises
// only when it is full. A stalled output holds its word and the sequencer
// holds its step. Reset (synchronous) empties the queue and output register
// and returns brightness to 7 and the display enable to 1.
// ----------------------------------------------------------------------------
module clock_display_frame_sequencer #(
    parameter int QUEUE_DEPTH = cdfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command words
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire cdfs_pkg::t_in_word                i_in_word,
    // link bytes
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output cdfs_pkg::t_out_word                    o_out_word,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [cdfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [cdfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [2:0] r_brightness;
    logic       r_display_on;

    cdfs_pkg::t_frame w_front_frame;
    cdfs_pkg::t_frame w_head_frame;
    logic             w_queue_full;
    logic             w_head_valid;
    logic             w_push;
    logic             w_pop;

    // Configuration registers: the user must write them only while idle (not
    // enforced here), so the front may sample them combinationally at accept time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= cdfs_pkg::BRIGHTNESS_RESET;
            r_display_on <= cdfs_pkg::DISPLAY_ON_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cdfs_pkg::REG_BRIGHTNESS: r_brightness <= i_cfg_data[2:0];
                cdfs_pkg::REG_DISPLAY_ON: r_display_on <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Accept whenever the queue has room
    assign o_in_stall = w_queue_full;
    assign w_push     = i_in_valid && !w_queue_full;

    cdfs_front u_front (
        .i_word       (i_in_word),
        .i_brightness (r_brightness),
        .i_display_on (r_display_on),
        .o_frame      (w_front_frame)
    );

    cdfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_front_frame),
        .i_pop   (w_pop),
        .o_full  (w_queue_full),
        .o_valid (w_head_valid),
        .o_frame (w_head_frame)
    );

    cdfs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (w_head_valid),
        .i_frame       (w_head_frame),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word)
    );

endmodule
`default_nettype wire
